/* design/harness_continuity_classifier_top_macros.svh */
// Assertion macros shared by the checker files.
`ifndef HARNESS_CONTINUITY_CLASSIFIER_TOP_MACROS_SVH
`define HARNESS_CONTINUITY_CLASSIFIER_TOP_MACROS_SVH
// same-cycle implication, sampled on clk, off during reset
`define HCC_ASSERT_NOW(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) else $error(msg);
// next-cycle implication
`define HCC_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) else $error(msg);
`endif

/* design/hcc_pkg.sv */
// Shared types, codes and constants of the harness continuity classifier.
`timescale 1ns / 1ps
package hcc_pkg;
	localparam int HCC_PINS = 128;
	localparam int LINE_W = 128;
	localparam int PIN_W = 7;
	localparam int CNT_W = 8;
	localparam int CMD_W = 3;
	localparam int VERD_W = 4;
	localparam logic [CNT_W-1:0] TP_RESET = 8'd100;
	localparam logic [CNT_W-1:0] NO_PIN = 8'd128;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LEARN = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WRITE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_START = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TEST = 3'd4;
	localparam logic [CMD_W-1:0] CMD_PROBE = 3'd5;

	localparam logic [VERD_W-1:0] V_ACK = 4'd0;
	localparam logic [VERD_W-1:0] V_ERROR = 4'd1;
	localparam logic [VERD_W-1:0] V_NORMAL = 4'd2;
	localparam logic [VERD_W-1:0] V_OPEN = 4'd3;
	localparam logic [VERD_W-1:0] V_SHORT = 4'd4;
	localparam logic [VERD_W-1:0] V_MISPLACED = 4'd5;
	localparam logic [VERD_W-1:0] V_LEARNED = 4'd6;
	localparam logic [VERD_W-1:0] V_LEARN_OPEN = 4'd7;
	localparam logic [VERD_W-1:0] V_LEARN_MULT = 4'd8;

	// request as classified by the front end
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [PIN_W-1:0] a_pin;
		logic [PIN_W-1:0] b_pin;
		logic [LINE_W-1:0] pattern;   // 1 = connected, masked to n pins
		logic a_ok;
		logic b_ok;
		logic [CNT_W-1:0] n;
	} hcc_req_t;

	// result and live tallies of the back end
	typedef struct packed {
		logic [VERD_W-1:0] verdict;
		logic [CNT_W-1:0] expected_pin;
		logic [CNT_W-1:0] actual_pin;
		logic [CNT_W-1:0] resp_count;
		logic [PIN_W-1:0] group_index;
		logic new_group;
		logic [CNT_W-1:0] normal_tally;
		logic [CNT_W-1:0] open_tally;
		logic [CNT_W-1:0] short_group_tally;
		logic [CNT_W-1:0] misplaced_tally;
		logic [CNT_W-1:0] learned_tally;
		logic learn_passed;
	} hcc_res_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v,
			input logic [CNT_W-1:0] lim);
		return (v < lim) ? v + 1'b1 : lim;
	endfunction
endpackage

/* design/hcc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* design/hcc_front.sv */
// Front end: pin-count register, line masking and range checks.
`timescale 1ns / 1ps
module hcc_front import hcc_pkg::*; #(
	parameter int PINS = HCC_PINS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic [CMD_W-1:0] command,
	input  logic [PIN_W-1:0] a_pin,
	input  logic [PIN_W-1:0] b_pin,
	input  logic [63:0] lines_low,
	input  logic [63:0] lines_high,
	output hcc_req_t req
);
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] n;
	logic [LINE_W-1:0] mask;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TP_RESET;
		end else if (cfg_valid) begin
			total_q <= cfg_data;
		end
	end

	assign n = (total_q > CNT_W'(PINS)) ? CNT_W'(PINS) : total_q;

	always_comb begin
		for (int j = 0; j < LINE_W; j++) begin
			mask[j] = CNT_W'(j) < n;
		end
	end

	always_comb begin
		req.cmd = command;
		req.a_pin = a_pin;
		req.b_pin = b_pin;
		req.pattern = ~{lines_high, lines_low} & mask;
		req.a_ok = {1'b0, a_pin} < n;
		req.b_ok = {1'b0, b_pin} < n;
		req.n = n;
	end
endmodule

/* design/hcc_queue.sv */
// Two-entry request queue between front and back end.
`timescale 1ns / 1ps
module hcc_queue import hcc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  hcc_req_t wdata,
	output logic full,
	input  logic pop,
	output logic valid,
	output hcc_req_t rdata
);
	hcc_req_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic do_push;

	assign full = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign do_push = push && !full;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (pop && valid) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(pop && valid);
		end
	end
endmodule

/* design/hcc_back.sv */
// Back end: line scan, map and group table, tallies and result register.
`timescale 1ns / 1ps
module hcc_back import hcc_pkg::*; #(
	parameter int PINS = HCC_PINS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  hcc_req_t q_data,
	output logic q_pop,
	output logic res_valid,
	input  logic res_pop,
	output hcc_res_t res
);
	localparam int AW = $clog2(PINS);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SCAN = 6'b000010,
		ST_EXEC = 6'b000100,
		ST_SRD  = 6'b001000,
		ST_SCMP = 6'b010000,
		ST_SADD = 6'b100000
	} st_t;

	st_t state_q;
	hcc_req_t item_q;
	logic [3:0] k_q;
	logic [CNT_W-1:0] cnt_q, act_q;
	logic hit_q;
	logic [AW-1:0] sidx_q;
	logic [PINS-1:0] valid_q;
	logic [CNT_W-1:0] entries_q, learned_q, normal_q, open_q, miss_q, gcount_q;
	logic res_valid_q;
	logic [VERD_W-1:0] verd_q;
	logic [CNT_W-1:0] exp_q, ract_q, rcnt_q;
	logic [PIN_W-1:0] gidx_q;
	logic gnew_q;

	logic start;
	logic [7:0] chunk;
	logic [3:0] pc;
	logic [2:0] lo;
	logic [AW-1:0] a_idx;
	logic map_we;
	logic [PIN_W-1:0] map_wdata, map_rdata;
	logic grp_we;
	logic [LINE_W-1:0] grp_rdata;
	logic [CNT_W-1:0] lim;
	logic [CNT_W-1:0] map_exp;
	logic [11:0] lp_lhs, lp_rhs;

	assign lim = CNT_W'(PINS);
	assign start = (state_q == ST_IDLE) && q_valid && !res_valid_q;
	assign q_pop = start;
	assign a_idx = item_q.a_pin[AW-1:0];

	// popcount and lowest set bit of the current eight lines
	assign chunk = item_q.pattern[k_q*8 +: 8];
	always_comb begin
		pc = '0;
		lo = '0;
		for (int i = 7; i >= 0; i--) begin
			pc = pc + 4'(chunk[i]);
			if (chunk[i]) lo = 3'(i);
		end
	end

	assign map_exp = valid_q[a_idx] ? {1'b0, map_rdata} : NO_PIN;
	assign map_we = (state_q == ST_EXEC) && item_q.a_ok &&
		(((item_q.cmd == CMD_WRITE) && item_q.b_ok) ||
		((item_q.cmd == CMD_LEARN) && (cnt_q == 8'd1)));
	assign map_wdata = (item_q.cmd == CMD_WRITE) ? item_q.b_pin : act_q[PIN_W-1:0];
	assign grp_we = (state_q == ST_SADD) && (gcount_q < lim);

	hcc_ram #(.WIDTH(PIN_W), .DEPTH(PINS)) u_map (
		.clk(clk), .we(map_we), .waddr(a_idx), .wdata(map_wdata),
		.re(start), .raddr(q_data.a_pin[AW-1:0]), .rdata(map_rdata)
	);

	hcc_ram #(.WIDTH(LINE_W), .DEPTH(PINS)) u_grp (
		.clk(clk), .we(grp_we), .waddr(gcount_q[AW-1:0]), .wdata(item_q.pattern),
		.re(state_q == ST_SRD), .raddr(sidx_q), .rdata(grp_rdata)
	);

	always_ff @(posedge clk) begin
		if (start) begin
			item_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			cnt_q <= '0;
			act_q <= NO_PIN;
			hit_q <= 1'b0;
			sidx_q <= '0;
			valid_q <= '0;
			entries_q <= '0;
			learned_q <= '0;
			normal_q <= '0;
			open_q <= '0;
			miss_q <= '0;
			gcount_q <= '0;
			res_valid_q <= 1'b0;
			verd_q <= V_ACK;
			exp_q <= NO_PIN;
			ract_q <= NO_PIN;
			rcnt_q <= '0;
			gidx_q <= '0;
			gnew_q <= 1'b0;
		end else begin
			if (res_valid_q && res_pop) res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						k_q <= '0;
						cnt_q <= '0;
						act_q <= NO_PIN;
						hit_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + CNT_W'(pc);
					if (!hit_q && (chunk != 8'd0)) begin
						act_q <= {1'b0, k_q, lo};
						hit_q <= 1'b1;
					end
					k_q <= k_q + 1'b1;
					if (k_q == 4'd15) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					verd_q <= V_ERROR;
					exp_q <= NO_PIN;
					ract_q <= NO_PIN;
					rcnt_q <= '0;
					gidx_q <= '0;
					gnew_q <= 1'b0;
					res_valid_q <= 1'b1;
					state_q <= ST_IDLE;
					case (item_q.cmd)
						CMD_CLEAR: begin
							valid_q <= '0;
							entries_q <= '0;
							learned_q <= '0;
							verd_q <= V_ACK;
						end
						CMD_WRITE: begin
							if (item_q.a_ok && item_q.b_ok) begin
								if (!valid_q[a_idx]) entries_q <= sat_inc(entries_q, lim);
								valid_q[a_idx] <= 1'b1;
								exp_q <= {1'b0, item_q.b_pin};
								verd_q <= V_ACK;
							end
						end
						CMD_START: begin
							if (entries_q != '0) begin
								gcount_q <= '0;
								normal_q <= '0;
								open_q <= '0;
								miss_q <= '0;
								verd_q <= V_ACK;
							end
						end
						CMD_LEARN, CMD_TEST, CMD_PROBE: begin
							if (item_q.a_ok) begin
								ract_q <= act_q;
								rcnt_q <= cnt_q;
								exp_q <= map_exp;
								if (item_q.cmd == CMD_LEARN) begin
									if (cnt_q == 8'd1) begin
										if (!valid_q[a_idx]) entries_q <= sat_inc(entries_q, lim);
										valid_q[a_idx] <= 1'b1;
										learned_q <= sat_inc(learned_q, lim);
										exp_q <= act_q;
										verd_q <= V_LEARNED;
									end else begin
										verd_q <= (cnt_q == '0) ? V_LEARN_OPEN : V_LEARN_MULT;
									end
								end else if (item_q.cmd == CMD_PROBE) begin
									verd_q <= V_ACK;
								end else if (cnt_q == '0) begin
									open_q <= sat_inc(open_q, lim);
									verd_q <= V_OPEN;
								end else if (cnt_q == 8'd1) begin
									if (act_q == map_exp) begin
										normal_q <= sat_inc(normal_q, lim);
										verd_q <= V_NORMAL;
									end else begin
										miss_q <= sat_inc(miss_q, lim);
										verd_q <= V_MISPLACED;
									end
								end else begin
									// short: look for the same pattern first
									verd_q <= V_SHORT;
									res_valid_q <= 1'b0;
									sidx_q <= '0;
									state_q <= (gcount_q == '0) ? ST_SADD : ST_SRD;
								end
							end
						end
						default: begin
						end
					endcase
				end
				ST_SRD: begin
					state_q <= ST_SCMP;
				end
				ST_SCMP: begin
					if (grp_rdata == item_q.pattern) begin
						gidx_q <= PIN_W'(sidx_q);
						res_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else if ((CNT_W'(sidx_q) + 1'b1) < gcount_q) begin
						sidx_q <= sidx_q + 1'b1;
						state_q <= ST_SRD;
					end else begin
						state_q <= ST_SADD;
					end
				end
				ST_SADD: begin
					if (gcount_q < lim) begin
						gidx_q <= PIN_W'(gcount_q);
						gnew_q <= 1'b1;
						gcount_q <= gcount_q + 1'b1;
					end else begin
						gidx_q <= PIN_W'(PINS - 1);
					end
					res_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign lp_lhs = {4'b0, learned_q} * 12'd10;
	assign lp_rhs = {4'b0, item_q.n} * 12'd4;

	assign res_valid = res_valid_q;
	always_comb begin
		res.verdict = verd_q;
		res.expected_pin = exp_q;
		res.actual_pin = ract_q;
		res.resp_count = rcnt_q;
		res.group_index = gidx_q;
		res.new_group = gnew_q;
		res.normal_tally = normal_q;
		res.open_tally = open_q;
		res.short_group_tally = gcount_q;
		res.misplaced_tally = miss_q;
		res.learned_tally = learned_q;
		res.learn_passed = lp_lhs >= lp_rhs;
	end
endmodule

/* design/harness_continuity_classifier_top.sv */
// Top level of the harness continuity classifier.
//
//  channel   handshake            payload
//  --------  -------------------  ------------------------------------------
//  request   push / full          command, a_pin, b_pin, lines_low/high
//  result    empty / pop          verdict ... learn_passed (12 fields)
//  config    cfg_valid/cfg_ready  cfg_data -> pin count in use
//
// A request goes through idle pickup, a scan of eight lines a cycle and
// execute; a short pattern then reads and compares the stored groups one
// by one, limited by the single read port of the group RAM, and adds a group if none matches.
// The front queue holds two requests, so push keeps working while a result
// waits; the back end starts the next request once the result is popped.
// Reset is asynchronous; the map's valid bits clear at once, no RAM sweep.
`timescale 1ns / 1ps
module harness_continuity_classifier_top import hcc_pkg::*; #(
	parameter int PINS = HCC_PINS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic push,
	output logic full,
	input  logic [CMD_W-1:0] command,
	input  logic [PIN_W-1:0] a_pin,
	input  logic [PIN_W-1:0] b_pin,
	input  logic [63:0] lines_low,
	input  logic [63:0] lines_high,
	output logic empty,
	input  logic pop,
	output logic [VERD_W-1:0] verdict,
	output logic [CNT_W-1:0] expected_pin,
	output logic [CNT_W-1:0] actual_pin,
	output logic [CNT_W-1:0] resp_count,
	output logic [PIN_W-1:0] group_index,
	output logic new_group,
	output logic [CNT_W-1:0] normal_tally,
	output logic [CNT_W-1:0] open_tally,
	output logic [CNT_W-1:0] short_group_tally,
	output logic [CNT_W-1:0] misplaced_tally,
	output logic [CNT_W-1:0] learned_tally,
	output logic learn_passed
);
	hcc_req_t front_req, head_req;
	hcc_res_t res;
	logic head_valid, head_pop, res_valid;

	hcc_front #(.PINS(PINS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.command(command), .a_pin(a_pin), .b_pin(b_pin),
		.lines_low(lines_low), .lines_high(lines_high), .req(front_req)
	);

	// decouples request intake from the back end
	hcc_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(front_req), .full(full),
		.pop(head_pop), .valid(head_valid), .rdata(head_req)
	);

	hcc_back #(.PINS(PINS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(head_valid), .q_data(head_req), .q_pop(head_pop),
		.res_valid(res_valid), .res_pop(pop), .res(res)
	);

	assign empty = !res_valid;
	assign verdict = res.verdict;
	assign expected_pin = res.expected_pin;
	assign actual_pin = res.actual_pin;
	assign resp_count = res.resp_count;
	assign group_index = res.group_index;
	assign new_group = res.new_group;
	assign normal_tally = res.normal_tally;
	assign open_tally = res.open_tally;
	assign short_group_tally = res.short_group_tally;
	assign misplaced_tally = res.misplaced_tally;
	assign learned_tally = res.learned_tally;
	assign learn_passed = res.learn_passed;
endmodule

/* design/hcc_checker.sv */
// Port-level checks of the classifier, bound to the top level.
`timescale 1ns / 1ps
`include "harness_continuity_classifier_top_macros.svh"
module hcc_checker import hcc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input logic [VERD_W-1:0] verdict,
	input logic [CNT_W-1:0] actual_pin,
	input logic [CNT_W-1:0] resp_count,
	input logic new_group
);
	`HCC_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(verdict), "result dropped")
	`HCC_ASSERT_NOW(a_none, !empty && resp_count == 8'd0, actual_pin == NO_PIN, "stray pin")
	`HCC_ASSERT_NOW(a_some, !empty && resp_count != 8'd0, actual_pin < NO_PIN, "missing pin")
	`HCC_ASSERT_NOW(a_newgrp, !empty && new_group, verdict == V_SHORT, "new group outside short")
endmodule

bind harness_continuity_classifier_top hcc_checker u_hcc_checker (.*);

/* verif/tb_top.sv */
// Self-checking testbench of the harness continuity classifier.
`timescale 1ns / 1ps
import hcc_pkg::*;

class hcc_scoreboard;
	// mirror of the classifier state
	logic [7:0] pins_in_use;
	bit map_ok [128];
	logic [7:0] map_pin [128];
	int map_cnt, grp_cnt, norm_cnt, open_cnt, mis_cnt, learn_cnt;
	logic [127:0] grp_pat [128];
	hcc_res_t pending [$];
	int mismatches;

	function void clear_state();
		foreach (map_ok[i]) map_ok[i] = 0;
		map_cnt = 0; grp_cnt = 0; norm_cnt = 0; open_cnt = 0;
		mis_cnt = 0; learn_cnt = 0; pins_in_use = TP_RESET;
		mismatches = 0;
	endfunction

	function int bump(int v);
		return (v < HCC_PINS) ? v + 1 : HCC_PINS;
	endfunction

	// predict the result of one accepted request and queue it
	function void note_request(logic [2:0] cmd, logic [6:0] a, logic [6:0] b,
			logic [63:0] lo, logic [63:0] hi);
		hcc_res_t r;
		int n, cnt, act, found;
		logic [127:0] mask, conn;
		n = (pins_in_use > HCC_PINS) ? HCC_PINS : pins_in_use;
		mask = (n >= 128) ? '1 : ((128'd1 << n) - 1);
		conn = ~{hi, lo} & mask;
		r = '0;
		r.verdict = V_ERROR; r.expected_pin = NO_PIN; r.actual_pin = NO_PIN;
		cnt = 0; act = NO_PIN;
		if (cmd == CMD_CLEAR) begin
			foreach (map_ok[i]) map_ok[i] = 0;
			map_cnt = 0; learn_cnt = 0; r.verdict = V_ACK;
		end else if (cmd == CMD_WRITE) begin
			if (a < n && b < n) begin
				if (!map_ok[a]) map_cnt = bump(map_cnt);
				map_ok[a] = 1; map_pin[a] = {1'b0, b};
				r.expected_pin = {1'b0, b}; r.verdict = V_ACK;
			end
		end else if (cmd == CMD_START) begin
			if (map_cnt != 0) begin
				grp_cnt = 0; norm_cnt = 0; open_cnt = 0; mis_cnt = 0;
				r.verdict = V_ACK;
			end
		end else if ((cmd == CMD_LEARN || cmd == CMD_TEST || cmd == CMD_PROBE) && a < n) begin
			for (int i = 127; i >= 0; i--)
				if (conn[i]) begin
					cnt++; act = i;
				end
			r.resp_count = CNT_W'(cnt); r.actual_pin = CNT_W'(act);
			if (cmd == CMD_LEARN) begin
				if (cnt == 1) begin
					if (!map_ok[a]) map_cnt = bump(map_cnt);
					map_ok[a] = 1; map_pin[a] = CNT_W'(act);
					learn_cnt = bump(learn_cnt); r.verdict = V_LEARNED;
				end else
					r.verdict = (cnt == 0) ? V_LEARN_OPEN : V_LEARN_MULT;
				if (map_ok[a]) r.expected_pin = map_pin[a];
			end else begin
				if (map_ok[a]) r.expected_pin = map_pin[a];
				if (cmd == CMD_PROBE) r.verdict = V_ACK;
				else if (cnt == 0) begin
					open_cnt = bump(open_cnt); r.verdict = V_OPEN;
				end else if (cnt == 1) begin
					if (act == r.expected_pin) begin
						norm_cnt = bump(norm_cnt); r.verdict = V_NORMAL;
					end else begin
						mis_cnt = bump(mis_cnt); r.verdict = V_MISPLACED;
					end
				end else begin
					r.verdict = V_SHORT; found = -1;
					for (int i = 0; i < grp_cnt; i++)
						if (found < 0 && grp_pat[i] == conn) found = i;
					if (found >= 0) r.group_index = PIN_W'(found);
					else if (grp_cnt < HCC_PINS) begin
						grp_pat[grp_cnt] = conn; r.group_index = PIN_W'(grp_cnt);
						grp_cnt++; r.new_group = 1;
					end else r.group_index = PIN_W'(HCC_PINS - 1);
				end
			end
		end
		r.normal_tally = CNT_W'(norm_cnt); r.open_tally = CNT_W'(open_cnt);
		r.short_group_tally = CNT_W'(grp_cnt); r.misplaced_tally = CNT_W'(mis_cnt);
		r.learned_tally = CNT_W'(learn_cnt);
		r.learn_passed = (learn_cnt * 10 >= n * 4);
		pending.push_back(r);
	endfunction

	function void check_result(hcc_res_t got);
		hcc_res_t want;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result %p", got);
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10) $display("mismatch\n exp %p\n got %p", want, got);
		end
	endfunction
endclass

module tb_top;
	import hcc_pkg::*;
	logic clk = 0, arst_n = 0;
	logic cfg_valid = 0, push = 0, pop = 0;
	logic [7:0] cfg_data = '0;
	logic [2:0] command = '0;
	logic [6:0] a_pin = '0, b_pin = '0;
	logic [63:0] lines_low = '1, lines_high = '1;
	logic cfg_ready, full, empty;
	hcc_res_t res;
	hcc_scoreboard sb;
	bit quiet = 0;        // last part of the run: no idling
	bit hold_pop = 0;     // long receiver hold-off
	int pins_now = 100;

	always #2 clk = ~clk;

	harness_continuity_classifier_top dut (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_data, .push, .full,
		.command, .a_pin, .b_pin, .lines_low, .lines_high, .empty, .pop,
		.verdict(res.verdict), .expected_pin(res.expected_pin),
		.actual_pin(res.actual_pin), .resp_count(res.resp_count),
		.group_index(res.group_index), .new_group(res.new_group),
		.normal_tally(res.normal_tally), .open_tally(res.open_tally),
		.short_group_tally(res.short_group_tally),
		.misplaced_tally(res.misplaced_tally), .learned_tally(res.learned_tally),
		.learn_passed(res.learn_passed)
	);

	// Result side: check on every accepted pop, idle in random bursts.
	int pop_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) sb.check_result(res);
			if (pop_gap > 0) begin
				pop_gap <= pop_gap - 1;
				pop <= 0;
			end else if (hold_pop) begin
				pop <= 0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				pop_gap <= $urandom_range(1, 13) - 1;
				pop <= 0;
			end else
				pop <= 1;
		end
	end

	// Offer one request, hold it until the block takes it; push stays high
	// for a request that follows at once.
	task automatic send(logic [2:0] c, logic [6:0] a, logic [6:0] b,
			logic [63:0] lo, logic [63:0] hi);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 13);
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		push <= 1; command <= c; a_pin <= a; b_pin <= b;
		lines_low <= lo; lines_high <= hi;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_request(c, a, b, lo, hi);
	endtask

	task automatic drain();
		push <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_pins(logic [7:0] v);
		drain();
		cfg_valid <= 1; cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		sb.pins_in_use = v;
		pins_now = (v > 128) ? 128 : ((v == 0) ? 1 : v);
	endtask

	// B pattern with exactly the given pin connected (low level)
	function automatic logic [127:0] only(int p);
		logic [127:0] l;
		l = '1; l[p] = 0;
		return l;
	endfunction

	// random request biased toward well-formed harness sessions
	task automatic random_request();
		logic [127:0] l;
		logic [6:0] a;
		int k, pick;
		a = 7'($urandom_range(0, pins_now - 1));
		if ($urandom_range(0, 19) == 0) a = 7'($urandom_range(0, 127));
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 5))
			0: l = {$urandom, $urandom, $urandom, $urandom};
			1: l = '1;
			2, 3: l = only($urandom_range(0, pins_now - 1));
			4: begin
				l = '1;
				k = $urandom_range(2, 4);
				// a small pool of shorts so that groups repeat
				for (int i = 0; i < k; i++) l[(a + i * 3 + pick % 2) % pins_now] = 0;
			end
			default: l = only(sb.map_ok[a] ? sb.map_pin[a] : a);
		endcase
		if (pick < 2) send(CMD_CLEAR, a, 0, l[63:0], l[127:64]);
		else if (pick < 10) send(CMD_LEARN, a, 0, l[63:0], l[127:64]);
		else if (pick < 16) send(CMD_WRITE, a, 7'($urandom_range(0, 127) % (pins_now + 2)),
			l[63:0], l[127:64]);
		else if (pick < 19) send(CMD_START, a, 0, l[63:0], l[127:64]);
		else if (pick < 88) send(CMD_TEST, a, 0, l[63:0], l[127:64]);
		else if (pick < 97) send(CMD_PROBE, a, 0, l[63:0], l[127:64]);
		else send(3'($urandom_range(6, 7)), a, 7'($urandom), l[63:0], l[127:64]);
	endtask

	initial begin
		logic [127:0] l;
		int waited;
		sb = new();
		sb.clear_state();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty map, range errors, unused codes, extremes
		send(CMD_START, 0, 0, '1, '1);
		send(CMD_TEST, 99, 0, '0, '0);
		send(CMD_TEST, 100, 0, '0, '0);
		send(CMD_WRITE, 5, 100, '1, '1);
		send(CMD_WRITE, 5, 99, '1, '1);
		send(CMD_WRITE, 5, 7, '1, '1);
		send(3'd6, 1, 1, '0, '0);
		send(3'd7, 127, 127, '1, '1);
		send(CMD_LEARN, 2, 0, '1, '1);
		send(CMD_LEARN, 2, 0, '0, '0);
		l = only(3); send(CMD_LEARN, 2, 0, l[63:0], l[127:64]);
		send(CMD_START, 0, 0, '1, '1);
		l = only(3); send(CMD_TEST, 2, 0, l[63:0], l[127:64]);
		l = only(8); send(CMD_TEST, 2, 0, l[63:0], l[127:64]);
		l = only(8); send(CMD_TEST, 9, 0, l[63:0], l[127:64]);
		send(CMD_TEST, 2, 0, '1, '1);
		send(CMD_TEST, 2, 0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
		send(CMD_TEST, 4, 0, 64'h0, 64'h0);
		send(CMD_PROBE, 4, 0, 64'hFFFF_FFFF_FFFF_FFF0, '1);
		send(CMD_CLEAR, 0, 0, '1, '1);

		// full width, fill the group table to saturation
		set_pins(8'd128);
		send(CMD_WRITE, 127, 127, '1, '1);
		send(CMD_START, 0, 0, '1, '1);
		send(CMD_TEST, 127, 0, '1, 64'h7FFF_FFFF_FFFF_FFFF);
		for (int i = 0; i < 132; i++) begin
			l = '1; l[i % 128] = 0; l[(i + 1 + i / 128) % 128] = 0;
			send(CMD_TEST, 7'(i % 128), 0, l[63:0], l[127:64]);
		end
		for (int i = 0; i < 260; i++) send(CMD_TEST, 0, 0, '1, '1);

		set_pins(8'd1);
		send(CMD_WRITE, 0, 0, '0, '0);
		send(CMD_TEST, 0, 0, '0, '0);
		send(CMD_TEST, 1, 0, '0, '0);
		set_pins(8'd255);
		send(CMD_PROBE, 127, 0, '0, '0);
		set_pins(8'd0);
		send(CMD_PROBE, 0, 0, '0, '0);
		send(CMD_WRITE, 0, 0, '0, '0);

		// random phases over several pin counts
		for (int ph = 0; ph < 5; ph++) begin
			set_pins(ph == 0 ? 8'd100 : ph == 1 ? 8'd64 : ph == 2 ? 8'd65 :
				8'($urandom_range(2, 128)));
			for (int i = 0; i < 20; i++) send(CMD_WRITE, 7'(i % pins_now),
				7'($urandom_range(0, pins_now - 1)), '1, '1);
			send(CMD_START, 0, 0, '1, '1);
			for (int i = 0; i < 270; i++) random_request();
			if (ph == 2) drain();
		end
		// receiver hold-off long enough for the block to back up
		hold_pop = 1;
		fork
			begin
				waited = 0;
				while (waited < 300) begin
					@(posedge clk); waited++;
				end
				hold_pop = 0;
			end
			begin
				for (int i = 0; i < 20; i++) random_request();
				push <= 0;
			end
		join
		quiet = 1;
		for (int i = 0; i < 200; i++) random_request();
		drain();
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("PASS harness_continuity_classifier_top");
		else
			$display("FAIL harness_continuity_classifier_top");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL harness_continuity_classifier_top");
		$finish;
	end
endmodule
